>>> rtl/core/tssd_pkg.sv
// Shared types, constants and helpers for the TCP SYN scan detector table.
`default_nettype none
package tssd_pkg;

	localparam int NUM_ENTRIES = 32;
	localparam int COUNT_W     = 16;
	localparam int IDX_W       = $clog2(NUM_ENTRIES);
	localparam int OCC_W       = $clog2(NUM_ENTRIES + 1);
	localparam int LIM_W       = 9;
	localparam int PROD_W      = COUNT_W + LIM_W;

	localparam logic [7:0] FLAG_SYN    = 8'h02;
	localparam logic [7:0] FLAG_ACK    = 8'h10;
	localparam logic [7:0] FLAG_SYNACK = 8'h12;

	localparam logic [1:0] KIND_SYN    = 2'd0;
	localparam logic [1:0] KIND_ACK    = 2'd1;
	localparam logic [1:0] KIND_SYNACK = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	localparam logic [1:0] REG_BURST_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_RATIO_LIMIT     = 2'd1;
	localparam logic [1:0] REG_RETAIN_COUNT    = 2'd2;

	localparam logic [15:0] BURST_THRESHOLD_RST = 16'd4;
	localparam logic [7:0]  RATIO_LIMIT_RST     = 8'd3;
	localparam logic [5:0]  RETAIN_COUNT_RST    = 6'd20;

	typedef struct packed {
		logic        mode;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [7:0]  tcp_flags;
	} in_word_t;

	typedef struct packed {
		logic        entry_valid;
		logic [31:0] host_ip;
		logic        burst_alarm;
		logic        ratio_alarm;
		logic [15:0] syn_total;
		logic [15:0] ack_total;
		logic [15:0] synack_total;
		logic        last_slot;
	} out_word_t;

	typedef struct packed {
		logic [31:0]        key;
		logic [COUNT_W-1:0] syn;
		logic [COUNT_W-1:0] ack;
		logic [COUNT_W-1:0] synack;
		logic [COUNT_W-1:0] prev;
	} entry_t;

	typedef struct packed {
		logic load;
		logic issue_look;
		logic wr_hit;
		logic wr_ins;
		logic issue_sweep;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic kind_none;
		logic match;
		logic scan_end;
		logic sweep_end;
		logic pipe_empty;
	} sts_t;

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		return (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/tssd_ctrl.sv
// Controller state machine: sequences decode, table lookup/insert and check sweep.
`default_nettype none
module tssd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire tssd_pkg::sts_t sts,
	output tssd_pkg::cmd_t     cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_LOOK   = 3'd2;
	localparam logic [2:0] ST_SWEEP  = 3'd3;
	localparam logic [2:0] ST_FLUSH  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	assign busy = (state_q != ST_IDLE) || !sts.pipe_empty;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (start && !busy) begin
					cmd.load  = 1'b1;
					state_nxt = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.mode) begin
					state_nxt = ST_SWEEP;
				end else if (sts.kind_none) begin
					state_nxt = ST_IDLE;
				end else begin
					state_nxt = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (sts.match) begin
					cmd.wr_hit = 1'b1;
					state_nxt  = ST_IDLE;
				end else if (sts.scan_end) begin
					cmd.wr_ins = 1'b1;
					state_nxt  = ST_IDLE;
				end else begin
					cmd.issue_look = 1'b1;
				end
			end
			ST_SWEEP: begin
				cmd.issue_sweep = 1'b1;
				if (sts.sweep_end) begin
					state_nxt = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (sts.pipe_empty) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/tssd_datapath.sv
// Datapath: config registers, entry memory, lookup compare, counter update, sweep pipeline.
`default_nettype none
module tssd_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tssd_pkg::in_word_t item,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_idx,
	input  wire logic [15:0]        cfg_wdata,
	input  wire tssd_pkg::cmd_t     cmd,
	output tssd_pkg::sts_t          sts,
	output tssd_pkg::out_word_t     result,
	output logic                    result_valid
);

	localparam int N     = tssd_pkg::NUM_ENTRIES;
	localparam int IDX_W = tssd_pkg::IDX_W;
	localparam int OCC_W = tssd_pkg::OCC_W;
	localparam int CW    = tssd_pkg::COUNT_W;
	localparam int LW    = tssd_pkg::LIM_W;
	localparam int PW    = tssd_pkg::PROD_W;

	logic [15:0]      burst_thr_q;
	logic [7:0]       ratio_lim_q;
	logic [5:0]       retain_q;
	logic [OCC_W-1:0] occ_q;
	logic [OCC_W-1:0] idx_q;

	logic             mode_q;
	logic [1:0]       kind_q;
	logic [31:0]      key_q;

	tssd_pkg::entry_t mem [N];
	tssd_pkg::entry_t rd_q;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             we;
	logic [IDX_W-1:0] wr_addr;
	tssd_pkg::entry_t wr_data;

	logic             look_s1;
	logic             sv_s1;
	logic             live_s1;
	logic             last_s1;
	logic [IDX_W-1:0] slot_s1;

	logic             sv_s2;
	logic             live_s2;
	logic             last_s2;
	logic             burst_s2;
	logic [31:0]      key_s2;
	logic [CW-1:0]    syn_s2;
	logic [CW-1:0]    ack_s2;
	logic [CW-1:0]    sa_s2;
	logic [PW-1:0]    prod_s2;

	logic             live_now;
	logic [1:0]       kind_in;
	logic             full;
	logic [OCC_W-1:0] keep;
	logic [OCC_W-1:0] ins_slot;
	tssd_pkg::entry_t bumped;
	tssd_pkg::entry_t fresh;
	logic [LW-1:0]    lim1;

	always_comb begin
		case (item.tcp_flags)
			tssd_pkg::FLAG_SYN:    kind_in = tssd_pkg::KIND_SYN;
			tssd_pkg::FLAG_ACK:    kind_in = tssd_pkg::KIND_ACK;
			tssd_pkg::FLAG_SYNACK: kind_in = tssd_pkg::KIND_SYNACK;
			default:               kind_in = tssd_pkg::KIND_NONE;
		endcase
	end

	assign live_now = idx_q < occ_q;
	assign full     = occ_q == OCC_W'(N);
	assign keep     = (OCC_W'(retain_q) > OCC_W'(N - 1)) ? OCC_W'(N - 1) : OCC_W'(retain_q);
	assign ins_slot = full ? keep : occ_q;
	assign lim1     = LW'(ratio_lim_q) + LW'(1);

	always_comb begin
		bumped = rd_q;
		case (kind_q)
			tssd_pkg::KIND_SYN:    bumped.syn    = tssd_pkg::sat_inc(rd_q.syn);
			tssd_pkg::KIND_ACK:    bumped.ack    = tssd_pkg::sat_inc(rd_q.ack);
			tssd_pkg::KIND_SYNACK: bumped.synack = tssd_pkg::sat_inc(rd_q.synack);
			default:               bumped = rd_q;
		endcase
	end

	always_comb begin
		fresh        = '0;
		fresh.key    = key_q;
		case (kind_q)
			tssd_pkg::KIND_SYN:    fresh.syn    = CW'(1);
			tssd_pkg::KIND_ACK:    fresh.ack    = CW'(1);
			tssd_pkg::KIND_SYNACK: fresh.synack = CW'(1);
			default:               fresh.syn    = '0;
		endcase
	end

	assign rd_en   = cmd.issue_look || (cmd.issue_sweep && live_now);
	assign rd_addr = idx_q[IDX_W-1:0];

	always_comb begin
		we      = 1'b0;
		wr_addr = slot_s1;
		wr_data = rd_q;
		if (cmd.wr_hit) begin
			we      = 1'b1;
			wr_data = bumped;
		end else if (cmd.wr_ins) begin
			we      = 1'b1;
			wr_addr = ins_slot[IDX_W-1:0];
			wr_data = fresh;
		end else if (sv_s1 && live_s1) begin
			we           = 1'b1;
			wr_data.prev = rd_q.syn;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_thr_q <= tssd_pkg::BURST_THRESHOLD_RST;
			ratio_lim_q <= tssd_pkg::RATIO_LIMIT_RST;
			retain_q    <= tssd_pkg::RETAIN_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				tssd_pkg::REG_BURST_THRESHOLD: burst_thr_q <= cfg_wdata;
				tssd_pkg::REG_RATIO_LIMIT:     ratio_lim_q <= cfg_wdata[7:0];
				tssd_pkg::REG_RETAIN_COUNT:    retain_q    <= cfg_wdata[5:0];
				default:                       burst_thr_q <= burst_thr_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q        <= '0;
			idx_q        <= '0;
			look_s1      <= 1'b0;
			sv_s1        <= 1'b0;
			sv_s2        <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.issue_look || cmd.issue_sweep) begin
				idx_q <= idx_q + OCC_W'(1);
			end
			if (cmd.wr_ins) begin
				occ_q <= ins_slot + OCC_W'(1);
			end
			look_s1      <= cmd.issue_look;
			sv_s1        <= cmd.issue_sweep;
			sv_s2        <= sv_s1;
			result_valid <= sv_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= item.mode;
			kind_q <= kind_in;
			key_q  <= (kind_in == tssd_pkg::KIND_SYN) ? item.src_ip : item.dst_ip;
		end
		if (cmd.issue_look || cmd.issue_sweep) begin
			slot_s1 <= idx_q[IDX_W-1:0];
			live_s1 <= live_now;
			last_s1 <= idx_q == OCC_W'(N - 1);
		end
		live_s2  <= live_s1;
		last_s2  <= last_s1;
		burst_s2 <= (rd_q.prev == '0) && (rd_q.syn > CW'(burst_thr_q));
		key_s2   <= rd_q.key;
		syn_s2   <= rd_q.syn;
		ack_s2   <= rd_q.ack;
		sa_s2    <= rd_q.synack;
		prod_s2  <= PW'(rd_q.synack) * PW'(lim1);
		result.entry_valid  <= live_s2;
		result.host_ip      <= live_s2 ? key_s2 : '0;
		result.burst_alarm  <= live_s2 && burst_s2;
		result.ratio_alarm  <= live_s2 && (sa_s2 != '0) && (PW'(syn_s2) >= prod_s2);
		result.syn_total    <= live_s2 ? 16'(syn_s2) : '0;
		result.ack_total    <= live_s2 ? 16'(ack_s2) : '0;
		result.synack_total <= live_s2 ? 16'(sa_s2) : '0;
		result.last_slot    <= last_s2;
	end

	assign sts.mode       = mode_q;
	assign sts.kind_none  = kind_q == tssd_pkg::KIND_NONE;
	assign sts.match      = look_s1 && (rd_q.key == key_q);
	assign sts.scan_end   = idx_q == occ_q;
	assign sts.sweep_end  = idx_q == OCC_W'(N - 1);
	assign sts.pipe_empty = !sv_s1 && !sv_s2;

endmodule
`default_nettype wire

>>> rtl/core/tcp_syn_scan_detector_table_core.sv
// Top level of the TCP SYN scan detector table: controller plus datapath.
//
// Usage: a word on item is taken at a clock edge where start is high and busy
// is low. mode 0 is a packet: a flags byte of exactly SYN counts against
// src_ip, exactly ACK or SYN-ACK against dst_ip, anything else is dropped.
// A packet gives no result. A known address has its counter bumped
// (saturating); an unknown one gets a new slot; a full table first drops
// back to the first retain_count slots (at most NUM_ENTRIES - 1).
// mode 1 is a check sweep: one result word per slot, NUM_ENTRIES words on
// consecutive cycles, each marked by result_valid for one cycle, the final
// one with last_slot set. The receiver cannot stall; results must be taken.
// A packet keeps busy high while the lookup reads one memory slot per cycle
// (a miss reads every occupied slot, a hit stops at its slot, ignored flags
// stop at decode). A sweep keeps busy high until its reads have drained from
// the sweep pipeline; its results are paced by the single memory read port.
// Configuration (cfg_we/cfg_idx/cfg_wdata) is to be written by the user only
// while busy is low; the block itself does not enforce this. Reset empties the
// table and loads the default register values.
`default_nettype none
module tcp_syn_scan_detector_table_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire tssd_pkg::in_word_t item,
	output tssd_pkg::out_word_t     result,
	output logic                    result_valid,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_idx,
	input  wire logic [15:0]        cfg_wdata
);

	tssd_pkg::cmd_t cmd;
	tssd_pkg::sts_t sts;

	tssd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	tssd_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.sts          (sts),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule
`default_nettype wire

>>> bench/tcp_syn_scan_detector_table_core_tb.sv
// Self-checking testbench for the TCP SYN scan detector table core.
`default_nettype none
module tcp_syn_scan_detector_table_core_tb;
	import tssd_pkg::*;

	localparam logic MODE_PACKET = 1'b0;
	localparam logic MODE_SWEEP  = 1'b1;
	localparam int   CYCLE_LIMIT = 3_000_000;
	localparam int   DRAIN       = NUM_ENTRIES + 8;
	localparam int   N_PHASES    = 5;

	class detector_scoreboard;
		logic [31:0]        host_key   [NUM_ENTRIES];
		logic [COUNT_W-1:0] syn_cnt    [NUM_ENTRIES];
		logic [COUNT_W-1:0] ack_cnt    [NUM_ENTRIES];
		logic [COUNT_W-1:0] synack_cnt [NUM_ENTRIES];
		logic [COUNT_W-1:0] last_syn   [NUM_ENTRIES];
		int                 occ;
		logic [15:0]        burst_thr;
		logic [7:0]         ratio_lim;
		logic [5:0]         retain;
		out_word_t          sweep_q[$];
		int                 errors;

		function new();
			occ       = 0;
			burst_thr = BURST_THRESHOLD_RST;
			ratio_lim = RATIO_LIMIT_RST;
			retain    = RETAIN_COUNT_RST;
			errors    = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] v);
			case (idx)
				REG_BURST_THRESHOLD: burst_thr = v;
				REG_RATIO_LIMIT:     ratio_lim = v[7:0];
				REG_RETAIN_COUNT:    retain    = v[5:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return sweep_q.size();
		endfunction

		function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] v);
			return (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
		endfunction

		function void count_packet(logic [31:0] addr, logic [1:0] kind);
			int slot;
			for (int i = 0; i < occ; i++) begin
				if (host_key[i] == addr) begin
					bump_slot(i, kind);
					return;
				end
			end
			// full table falls back to the retained prefix
			if (occ == NUM_ENTRIES)
				occ = (int'(retain) > NUM_ENTRIES - 1) ? NUM_ENTRIES - 1 : int'(retain);
			slot             = occ;
			host_key[slot]   = addr;
			syn_cnt[slot]    = '0;
			ack_cnt[slot]    = '0;
			synack_cnt[slot] = '0;
			last_syn[slot]   = '0;
			bump_slot(slot, kind);
			occ = slot + 1;
		endfunction

		function void bump_slot(int i, logic [1:0] kind);
			case (kind)
				KIND_SYN:    syn_cnt[i]    = bump(syn_cnt[i]);
				KIND_ACK:    ack_cnt[i]    = bump(ack_cnt[i]);
				KIND_SYNACK: synack_cnt[i] = bump(synack_cnt[i]);
				default: ;
			endcase
		endfunction

		function void take_word(in_word_t w);
			out_word_t r;
			if (w.mode == MODE_PACKET) begin
				if (w.tcp_flags == FLAG_SYN)
					count_packet(w.src_ip, KIND_SYN);
				else if (w.tcp_flags == FLAG_ACK)
					count_packet(w.dst_ip, KIND_ACK);
				else if (w.tcp_flags == FLAG_SYNACK)
					count_packet(w.dst_ip, KIND_SYNACK);
			end else begin
				for (int i = 0; i < NUM_ENTRIES; i++) begin
					r = '0;
					if (i < occ) begin
						r.entry_valid  = 1'b1;
						r.host_ip      = host_key[i];
						r.burst_alarm  = (last_syn[i] == '0) && (syn_cnt[i] > burst_thr);
						r.ratio_alarm  = (synack_cnt[i] != '0) &&
							((syn_cnt[i] / synack_cnt[i]) > COUNT_W'(ratio_lim));
						r.syn_total    = syn_cnt[i];
						r.ack_total    = ack_cnt[i];
						r.synack_total = synack_cnt[i];
						last_syn[i]    = syn_cnt[i];
					end
					r.last_slot = (i == NUM_ENTRIES - 1);
					sweep_q.push_back(r);
				end
			end
		endfunction

		function void cmp(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_word(out_word_t got);
			out_word_t want;
			if (sweep_q.size() == 0) begin
				$error("result word with none expected: %0h", got);
				errors++;
				return;
			end
			want = sweep_q.pop_front();
			cmp("entry_valid", 32'(want.entry_valid), 32'(got.entry_valid));
			cmp("host_ip", want.host_ip, got.host_ip);
			cmp("burst_alarm", 32'(want.burst_alarm), 32'(got.burst_alarm));
			cmp("ratio_alarm", 32'(want.ratio_alarm), 32'(got.ratio_alarm));
			cmp("syn_total", 32'(want.syn_total), 32'(got.syn_total));
			cmp("ack_total", 32'(want.ack_total), 32'(got.ack_total));
			cmp("synack_total", 32'(want.synack_total), 32'(got.synack_total));
			cmp("last_slot", 32'(want.last_slot), 32'(got.last_slot));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_word_t    item;
	out_word_t   result;
	logic        result_valid;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [15:0] cfg_wdata;

	detector_scoreboard sb;
	logic [31:0]        hot [8];

	tcp_syn_scan_detector_table_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result       (result),
		.result_valid (result_valid),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Verification failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.take_word(item);
			if (result_valid)
				sb.check_word(result);
		end
	end

	function automatic in_word_t mk(logic m, logic [31:0] s, logic [31:0] d, logic [7:0] f);
		in_word_t w;
		w.mode      = m;
		w.src_ip    = s;
		w.dst_ip    = d;
		w.tcp_flags = f;
		return w;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 50);
	endfunction

	function automatic logic [31:0] pick_addr();
		if ($urandom_range(0, 1) == 0)
			return hot[3'($urandom_range(0, 7))];
		return $urandom;
	endfunction

	function automatic in_word_t rand_word();
		logic [7:0] f;
		int         r;
		if ($urandom_range(0, 9) == 0)
			return mk(MODE_SWEEP, $urandom, $urandom, 8'($urandom_range(0, 255)));
		r = $urandom_range(0, 99);
		if (r < 30)
			f = FLAG_SYN;
		else if (r < 55)
			f = FLAG_ACK;
		else if (r < 85)
			f = FLAG_SYNACK;
		else
			f = 8'($urandom_range(0, 255));
		return mk(MODE_PACKET, pick_addr(), pick_addr(), f);
	endfunction

	task automatic send_word(in_word_t w);
		@(negedge clk);
		start <= 1'b1;
		item  <= w;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause(int n);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// hold off until every sweep word is back and the block is quiet
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
		while (busy) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= v;
		sb.set_reg(idx, v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// pushes fresh addresses until the table is full and one more forces a wrap
	task automatic fill_table(output logic [31:0] newest);
		int n;
		n = NUM_ENTRIES - sb.occ + 1;
		repeat (n) begin
			newest = $urandom;
			send_word(mk(MODE_PACKET, newest, $urandom, FLAG_SYN));
		end
	endtask

	task automatic run_random(int n, bit gappy);
		in_word_t w;
		int       counted;
		counted = 0;
		while (counted < n) begin
			w = rand_word();
			send_word(w);
			if (w.mode == MODE_SWEEP || w.tcp_flags == FLAG_SYN ||
			    w.tcp_flags == FLAG_ACK || w.tcp_flags == FLAG_SYNACK)
				counted++;
			if (gappy)
				pause(gap_len());
			if ($urandom_range(0, 29) == 0)
				settle();
		end
	endtask

	initial begin
		in_word_t    plan[$];
		logic [31:0] a;
		logic [15:0] thr_set [N_PHASES];
		logic [7:0]  lim_set [N_PHASES];
		logic [5:0]  keep_set[N_PHASES];
		bit          fill_set[N_PHASES];

		sb        = new();
		arst_n    = 1'b0;
		start     = 1'b0;
		item      = '0;
		cfg_we    = 1'b0;
		cfg_idx   = REG_BURST_THRESHOLD;
		cfg_wdata = '0;
		hot[0]    = 32'h0000_0000;
		hot[1]    = 32'hFFFF_FFFF;
		for (int i = 2; i < 8; i++)
			hot[i] = $urandom;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// directed: empty sweep, address extremes, ignored flags, burst and ratio
		a = $urandom;
		plan.push_back(mk(MODE_SWEEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
		plan.push_back(mk(MODE_PACKET, 32'h0, 32'hFFFF_FFFF, FLAG_SYN));
		plan.push_back(mk(MODE_PACKET, 32'hFFFF_FFFF, 32'h0, FLAG_SYN));
		plan.push_back(mk(MODE_PACKET, 32'h0, 32'hFFFF_FFFF, FLAG_ACK));
		plan.push_back(mk(MODE_PACKET, 32'hFFFF_FFFF, 32'h0, FLAG_SYNACK));
		plan.push_back(mk(MODE_PACKET, a, a, 8'h00));
		plan.push_back(mk(MODE_PACKET, a, a, 8'hFF));
		plan.push_back(mk(MODE_PACKET, a, a, 8'h03));
		plan.push_back(mk(MODE_PACKET, a, a, 8'h13));
		repeat (6)
			plan.push_back(mk(MODE_PACKET, a, $urandom, FLAG_SYN));
		plan.push_back(mk(MODE_PACKET, $urandom, a, FLAG_SYNACK));
		plan.push_back(mk(MODE_PACKET, $urandom, a, FLAG_ACK));
		plan.push_back(mk(MODE_SWEEP, 32'h0, 32'h0, 8'h00));
		plan.push_back(mk(MODE_PACKET, a, 32'h0, FLAG_SYN));
		plan.push_back(mk(MODE_SWEEP, $urandom, $urandom, FLAG_SYN));
		plan.push_back(mk(MODE_SWEEP, $urandom, $urandom, FLAG_SYNACK));
		foreach (plan[i]) begin
			send_word(plan[i]);
			pause(gap_len());
		end

		thr_set[0] = 16'd0;     lim_set[0] = 8'd0;   keep_set[0] = 6'd63; fill_set[0] = 1;
		thr_set[1] = 16'hFFFF;  lim_set[1] = 8'hFF;  keep_set[1] = 6'd0;  fill_set[1] = 1;
		thr_set[2] = 16'($urandom);  lim_set[2] = 8'($urandom_range(0, 255));
		keep_set[2] = 6'($urandom_range(1, 62));                        fill_set[2] = 0;
		thr_set[3] = BURST_THRESHOLD_RST; lim_set[3] = RATIO_LIMIT_RST;
		keep_set[3] = RETAIN_COUNT_RST;                                 fill_set[3] = 0;
		thr_set[4] = 16'd1;     lim_set[4] = 8'd1;   keep_set[4] = 6'd31; fill_set[4] = 1;

		for (int p = 0; p < N_PHASES; p++) begin
			settle();
			write_reg(REG_BURST_THRESHOLD, thr_set[p]);
			write_reg(REG_RATIO_LIMIT, {8'h00, lim_set[p]});
			write_reg(REG_RETAIN_COUNT, {10'h000, keep_set[p]});
			if (fill_set[p])
				fill_table(a);
			run_random(15, p != 3);
			send_word(mk(MODE_SWEEP, $urandom, $urandom, 8'($urandom_range(0, 255))));
		end

		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire

>>> tcp_syn_scan_detector_table_core.f
rtl/core/tssd_pkg.sv
rtl/core/tssd_ctrl.sv
rtl/core/tssd_datapath.sv
rtl/core/tcp_syn_scan_detector_table_core.sv
bench/tcp_syn_scan_detector_table_core_tb.sv
